// File: hdl/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg
// Types and constants shared by the XMODEM checksum receiver and its checker.
// ----------------------------------------------------------------------------
package xcr_pkg;

  localparam int DATA_BYTES = 128;
  // frame index of the checksum byte: SOH, seq and ~seq come first
  localparam logic [7:0] FRAME_SUM_INDEX = 8'(DATA_BYTES + 3);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_SINK = 2'd2;

  localparam logic [1:0] CFG_CONNECT_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_RESPONSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_ERROR_LIMIT      = 2'd2;

  localparam logic [23:0] CONNECT_TIMEOUT_RESET  = 24'd1000;
  localparam logic [23:0] RESPONSE_TIMEOUT_RESET = 24'd10000;
  localparam logic [3:0]  ERROR_LIMIT_RESET      = 4'd10;
  localparam logic [3:0]  ERROR_MAX              = 4'd15;

  typedef enum logic [4:0] {
    PH_START     = 5'b00001,
    PH_CONNECT   = 5'b00010,
    PH_VALIDATE  = 5'b00100,
    PH_WAIT_SINK = 5'b01000,
    PH_RESPONSE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       packet_good;
    logic       packet_bad;
    logic       transfer_done;
    logic [3:0] error_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] connect_timeout_ticks;
    logic [23:0] response_timeout_ticks;
    logic [3:0]  error_limit;
  } xcr_cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  frame_index;
    logic [7:0]  running_sum;
    logic [7:0]  seq_byte;
    logic        header_ok;
    logic [3:0]  errors;
    logic [23:0] timer_left;
    logic        timer_armed;
  } xcr_state_t;

endpackage

// File: hdl/xcr_step.sv
// ----------------------------------------------------------------------------
// xcr_step
// One receiver step: next state and up to two result items for one item.
// ----------------------------------------------------------------------------
module xcr_step import xcr_pkg::*; (
  input  xcr_state_t       cur,
  input  in_item_t         item,
  input  xcr_cfg_t         cfg,
  output xcr_state_t       nxt,
  output out_item_t [1:0]  res,
  output logic [1:0]       res_count
);

  function automatic out_item_t mk(input logic txv, input logic [7:0] txb,
                                   input logic pv, input logic [7:0] pb,
                                   input logic good, input logic bad,
                                   input logic done, input logic [3:0] err);
    out_item_t r;
    r.tx_valid      = txv;
    r.tx_byte       = txb;
    r.payload_valid = pv;
    r.payload_byte  = pb;
    r.packet_good   = good;
    r.packet_bad    = bad;
    r.transfer_done = done;
    r.error_count   = err;
    r.last          = 1'b0;
    return r;
  endfunction

  phase_t     ph;
  logic [1:0] n;
  logic       expired;
  logic       restart;
  logic       is_byte;
  logic       is_tick;
  logic [7:0] b;

  always_comb begin
    nxt     = cur;
    res     = '0;
    n       = 2'd0;
    expired = 1'b0;
    restart = 1'b0;
    is_byte = (item.operation == OP_BYTE);
    is_tick = (item.operation == OP_TICK);
    b       = item.rx_byte;
    ph      = cur.phase;

    // start state or a broken phase code opens the link first
    if (!(cur.phase inside {PH_CONNECT, PH_VALIDATE, PH_WAIT_SINK, PH_RESPONSE})) begin
      nxt.errors      = '0;
      nxt.frame_index = '0;
      res[n[0]]       = mk(1'b1, CH_NAK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 4'd0);
      n               = n + 2'd1;
      nxt.timer_left  = cfg.connect_timeout_ticks;
      nxt.timer_armed = 1'b1;
      nxt.phase       = PH_CONNECT;
      ph              = PH_CONNECT;
    end

    // tick handling on the timer as it stands after the start step
    if (is_tick && nxt.timer_armed) begin
      if (nxt.timer_left <= 24'd1) begin
        expired = 1'b1;
      end
    end

    unique case (ph)
      PH_CONNECT: begin
        if (is_byte && b == CH_SOH) begin
          nxt.frame_index = 8'd1;
          nxt.running_sum = '0;
          nxt.seq_byte    = '0;
          nxt.header_ok   = 1'b0;
          nxt.timer_armed = 1'b0;
          nxt.timer_left  = '0;
          nxt.phase       = PH_VALIDATE;
        end else if (is_tick && nxt.timer_armed) begin
          if (expired) begin
            res[n[0]]       = mk(1'b1, CH_NAK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, nxt.errors);
            n               = n + 2'd1;
            nxt.timer_left  = cfg.connect_timeout_ticks;
            nxt.timer_armed = 1'b1;
          end else begin
            nxt.timer_left = nxt.timer_left - 24'd1;
          end
        end
      end
      PH_VALIDATE: begin
        if (is_byte) begin
          if (cur.frame_index == 8'd1) begin
            nxt.seq_byte    = b;
            nxt.frame_index = 8'd2;
          end else if (cur.frame_index == 8'd2) begin
            nxt.header_ok   = (b == ~cur.seq_byte);
            nxt.frame_index = 8'd3;
          end else if (cur.frame_index < FRAME_SUM_INDEX) begin
            nxt.running_sum = cur.running_sum + b;
            res[n[0]]       = mk(1'b0, 8'd0, 1'b1, b, 1'b0, 1'b0, 1'b0, cur.errors);
            n               = n + 2'd1;
            nxt.frame_index = cur.frame_index + 8'd1;
          end else begin
            nxt.frame_index = '0;
            if (cur.header_ok && b == cur.running_sum) begin
              nxt.errors = '0;
              nxt.phase  = PH_WAIT_SINK;
              res[n[0]]  = mk(1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 4'd0);
              n          = n + 2'd1;
            end else begin
              if (cur.errors != ERROR_MAX) begin
                nxt.errors = cur.errors + 4'd1;
              end
              res[n[0]]       = mk(1'b1, CH_NAK, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, nxt.errors);
              n               = n + 2'd1;
              nxt.timer_left  = cfg.response_timeout_ticks;
              nxt.timer_armed = 1'b1;
              nxt.phase       = PH_RESPONSE;
              restart         = (nxt.errors >= cfg.error_limit);
            end
          end
        end
      end
      PH_WAIT_SINK: begin
        if (item.operation == OP_SINK) begin
          res[n[0]]       = mk(1'b1, CH_ACK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, cur.errors);
          n               = n + 2'd1;
          nxt.timer_left  = cfg.response_timeout_ticks;
          nxt.timer_armed = 1'b1;
          nxt.phase       = PH_RESPONSE;
        end
      end
      PH_RESPONSE: begin
        if (is_byte) begin
          if (b == CH_SOH) begin
            nxt.frame_index = 8'd1;
            nxt.running_sum = '0;
            nxt.seq_byte    = '0;
            nxt.header_ok   = 1'b0;
            nxt.timer_armed = 1'b0;
            nxt.timer_left  = '0;
            nxt.phase       = PH_VALIDATE;
          end else if (b == CH_EOT) begin
            nxt.errors = '0;
            res[n[0]]  = mk(1'b1, CH_ACK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 4'd0);
            n          = n + 2'd1;
            restart    = 1'b1;
          end
        end else if (is_tick && cur.timer_armed) begin
          if (expired) begin
            if (cur.errors != ERROR_MAX) begin
              nxt.errors = cur.errors + 4'd1;
            end
            res[n[0]]       = mk(1'b1, CH_NAK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, nxt.errors);
            n               = n + 2'd1;
            nxt.timer_left  = cfg.response_timeout_ticks;
            nxt.timer_armed = 1'b1;
            restart         = (nxt.errors >= cfg.error_limit);
          end else begin
            nxt.timer_left = cur.timer_left - 24'd1;
          end
        end
      end
      default: begin
      end
    endcase

    // link restart: error limit reached or end of transfer
    if (restart) begin
      nxt.errors      = '0;
      nxt.frame_index = '0;
      res[n[0]]       = mk(1'b1, CH_NAK, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 4'd0);
      n               = n + 2'd1;
      nxt.timer_left  = cfg.connect_timeout_ticks;
      nxt.timer_armed = 1'b1;
      nxt.phase       = PH_CONNECT;
    end

    // n is 1 or 2 here when anything was produced, so n[1] picks the final one
    if (n != 2'd0) begin
      res[n[1]].last = 1'b1;
    end
    res_count = n;
  end

endmodule

// File: hdl/xmodem_checksum_receiver.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// XMODEM receiver, 8-bit checksum, 128 data bytes per frame, streamed payload.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        input      in_valid / in_ready   in_data    (operation, rx_byte)
//  out       output     out_valid / out_ready out_data   (result item)
//  cfg       input      cfg_we                cfg_index, cfg_data
//
//  One item per cycle sustained while the result queue keeps room for two
//  results; an item that yields two results writes both into the queue.
//  Each item passes the input register, then one step into the result queue.
//  Input is taken when the input register is empty or the queue has room for two.
//  Synchronous reset returns to the start state and loads register defaults.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver import xcr_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  xcr_cfg_t         cfg;
  xcr_state_t       state;
  xcr_state_t       state_next;
  in_item_t         item;
  logic             item_valid;
  out_item_t [1:0]  res;
  logic [1:0]       res_count;
  logic             fire;
  logic             pop;

  out_item_t        queue [FIFO_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  // step only when the queue can take both results of the worst case
  assign fire     = item_valid && (count <= CW'(FIFO_DEPTH - 2));
  assign in_ready = !item_valid || fire;
  assign out_valid = (count != '0);
  assign out_data  = queue[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign count_next = count + CW'(fire ? res_count : 2'd0) - CW'(pop);

  xcr_step u_step (
    .cur       (state),
    .item      (item),
    .cfg       (cfg),
    .nxt       (state_next),
    .res       (res),
    .res_count (res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connect_timeout_ticks  <= CONNECT_TIMEOUT_RESET;
      cfg.response_timeout_ticks <= RESPONSE_TIMEOUT_RESET;
      cfg.error_limit            <= ERROR_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONNECT_TIMEOUT:  cfg.connect_timeout_ticks  <= cfg_data;
        CFG_RESPONSE_TIMEOUT: cfg.response_timeout_ticks <= cfg_data;
        CFG_ERROR_LIMIT:      cfg.error_limit            <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_START;
      state.frame_index <= '0;
      state.running_sum <= '0;
      state.seq_byte    <= '0;
      state.header_ok   <= 1'b0;
      state.errors      <= '0;
      state.timer_left  <= '0;
      state.timer_armed <= 1'b0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (fire) begin
        if (res_count == 2'd1) begin
          wr_ptr <= ptr_inc(wr_ptr);
        end else if (res_count == 2'd2) begin
          wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_count != 2'd0) begin
      queue[wr_ptr] <= res[0];
      if (res_count == 2'd2) begin
        queue[ptr_inc(wr_ptr)] <= res[1];
      end
    end
  end

endmodule

// File: hdl/xcr_checker.sv
// ----------------------------------------------------------------------------
// xcr_checker
// Port-level checks for the XMODEM checksum receiver, bound to the top level.
// ----------------------------------------------------------------------------
module xcr_port_checker import xcr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_data
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // input only backs up behind pending results
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // end of transfer is always followed by the reopening NAK
  a_done_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.transfer_done |-> !out_data.last)
    else $error("transfer_done result marked last");

  // a packet_good verdict carries a cleared error count and no control byte
  a_good_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.packet_good
      |-> !out_data.tx_valid && out_data.error_count == 4'd0 && out_data.last)
    else $error("packet_good result malformed");

endmodule

bind xmodem_checksum_receiver xcr_port_checker u_xcr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
